// ===== design/rmts_pkg.sv =====
// Shared types and constants of the region map transfer splitter.
`default_nettype none

package rmts_pkg;

    // Field widths of the words on both channels
    localparam int LINK_W      = 16;
    localparam int AMOUNT_W    = 32;
    localparam int ADDR_W      = 32;
    localparam int OP_W        = 2;
    localparam int IDX_OUT_W   = 3;
    localparam int CNT_OUT_W   = 4;
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 128;
    localparam int M_PAD_W     = 6;
    localparam int REGION_W    = LINK_W + ADDR_W + AMOUNT_W;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes on the input selector
    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_DISCONNECT = 2'd1,
        OP_TRANSFER   = 2'd2,
        OP_UNUSED     = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_REGION = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NO_LINK   = 2'd3
    } status_t;

    // Work kinds handed from the front to the back
    typedef enum logic [1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_DISCONNECT = 2'd1,
        KIND_TRANSFER   = 2'd2,
        KIND_EMPTY      = 2'd3
    } kind_t;

    // Classified word waiting in the queue
    typedef struct packed {
        kind_t                 kind;
        logic [LINK_W-1:0]     link_id;
        logic [AMOUNT_W-1:0]   amount;
        logic [ADDR_W-1:0]     address;
        logic                  is_write;
    } item_t;

    // One row of the region table
    typedef struct packed {
        logic [LINK_W-1:0]     link;
        logic [ADDR_W-1:0]     base;
        logic [AMOUNT_W-1:0]   bytes;
    } region_t;

    // One result word
    typedef struct packed {
        status_t               status;
        logic [IDX_OUT_W-1:0]  region_index;
        logic [LINK_W-1:0]     chunk_link;
        logic [ADDR_W-1:0]     local_address;
        logic [AMOUNT_W-1:0]   chunk_length;
        logic                  chunk_is_write;
        logic [ADDR_W-1:0]     assigned_base;
        logic [CNT_OUT_W-1:0]  regions_in_table;
        logic                  last;
    } result_t;

    localparam result_t RESULT_ZERO = '0;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG,
        ST_ONE,
        ST_FAIL,
        ST_CMP,
        ST_UNLINK,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/rmts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rmts_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/rmts_front.sv =====
// Front end: accepts input words, classifies them and queues the work.
`default_nettype none

module rmts_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rmts_pkg::OP_W-1:0]     s_operation,
    input  wire logic [rmts_pkg::LINK_W-1:0]   s_link_id,
    input  wire logic [rmts_pkg::AMOUNT_W-1:0] s_amount,
    input  wire logic [rmts_pkg::ADDR_W-1:0]   s_address,
    input  wire logic                          s_is_write,
    output logic                               q_valid,
    output rmts_pkg::item_t                    q_item,
    input  wire logic                          q_pop
);

    rmts_pkg::item_t queue_reg [rmts_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    rmts_pkg::item_t item_in;
    logic            keep;
    logic            push;

    // Classify the incoming word; the unused code is dropped here
    always_comb begin
        item_in.link_id  = s_link_id;
        item_in.amount   = s_amount;
        item_in.address  = s_address;
        item_in.is_write = s_is_write;
        item_in.kind     = rmts_pkg::KIND_REGISTER;
        keep             = 1'b1;
        unique case (rmts_pkg::op_t'(s_operation))
            rmts_pkg::OP_REGISTER: begin
                item_in.kind = rmts_pkg::KIND_REGISTER;
            end
            rmts_pkg::OP_DISCONNECT: begin
                item_in.kind = rmts_pkg::KIND_DISCONNECT;
            end
            rmts_pkg::OP_TRANSFER: begin
                item_in.kind = (s_amount == '0) ? rmts_pkg::KIND_EMPTY
                                                : rmts_pkg::KIND_TRANSFER;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'(rmts_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    ap_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(rmts_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    ap_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> cnt_reg != 2'd0)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== design/rmts_back.sv =====
// Back end: keeps the region table and turns queued work into result words.
`default_nettype none

module rmts_back #(
    parameter int MAX_REGIONS = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire rmts_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output rmts_pkg::result_t    m_result
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    rmts_pkg::back_state_t   state_reg, state_next;
    rmts_pkg::item_t         item_reg, item_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [rmts_pkg::LINK_W-1:0]   hit_link_reg, hit_link_next;
    logic [rmts_pkg::ADDR_W-1:0]   local_reg, local_next;
    logic [rmts_pkg::AMOUNT_W-1:0] avail_reg, avail_next;
    logic [rmts_pkg::AMOUNT_W-1:0] left_reg, left_next;
    logic [rmts_pkg::ADDR_W:0]     cur_reg, cur_next;
    logic [rmts_pkg::ADDR_W:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic [MAX_REGIONS-1:0]  conn_reg, conn_next;
    logic                    out_valid_reg, out_valid_next;
    rmts_pkg::result_t       res_reg, res_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    rmts_pkg::region_t       wr_region;
    logic [rmts_pkg::REGION_W-1:0] rd_data;
    rmts_pkg::region_t       rd_region;

    logic                    out_free;
    logic                    link_eq;
    logic                    hit;
    logic                    scan_end;
    logic                    full;
    logic                    take_all;
    logic [rmts_pkg::ADDR_W:0] end_sum;

    // Region table rows; read data always follows scan_idx_reg
    rmts_ram #(
        .WIDTH(rmts_pkg::REGION_W),
        .DEPTH(MAX_REGIONS)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_region),
        .rd_addr(scan_idx_next),
        .rd_data(rd_data)
    );

    assign rd_region = rmts_pkg::region_t'(rd_data);

    // Match logic for the row under the scan pointer
    assign out_free = !out_valid_reg || m_ready;
    assign end_sum  = {1'b0, rd_region.base} + {1'b0, rd_region.bytes};
    assign link_eq  = (rd_region.link == item_reg.link_id);
    assign hit      = conn_reg[scan_idx_reg] && !cur_reg[rmts_pkg::ADDR_W]
                      && (cur_reg >= {1'b0, rd_region.base}) && (cur_reg < end_sum);
    assign scan_end = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == total_reg);
    assign full     = (total_reg >= CNT_W'(MAX_REGIONS));
    assign take_all = (left_reg <= avail_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rmts_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_item.kind)
                        rmts_pkg::KIND_REGISTER: state_next = rmts_pkg::ST_REG;
                        rmts_pkg::KIND_EMPTY:    state_next = rmts_pkg::ST_ONE;
                        default: begin
                            state_next = (total_reg == '0) ? rmts_pkg::ST_FAIL
                                                           : rmts_pkg::ST_CMP;
                        end
                    endcase
                end
            end
            rmts_pkg::ST_REG, rmts_pkg::ST_ONE, rmts_pkg::ST_FAIL,
            rmts_pkg::ST_UNLINK: begin
                if (out_free) begin
                    state_next = rmts_pkg::ST_IDLE;
                end
            end
            rmts_pkg::ST_CMP: begin
                if (item_reg.kind == rmts_pkg::KIND_DISCONNECT && link_eq) begin
                    state_next = rmts_pkg::ST_UNLINK;
                end else if (item_reg.kind == rmts_pkg::KIND_TRANSFER && hit) begin
                    state_next = rmts_pkg::ST_EMIT;
                end else if (scan_end) begin
                    state_next = rmts_pkg::ST_FAIL;
                end
            end
            rmts_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = take_all ? rmts_pkg::ST_IDLE : rmts_pkg::ST_CMP;
                end
            end
            default: begin
                state_next = rmts_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates and result words
    always_comb begin
        item_next      = item_reg;
        scan_idx_next  = scan_idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_link_next  = hit_link_reg;
        local_next     = local_reg;
        avail_next     = avail_reg;
        left_next      = left_reg;
        cur_next       = cur_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        conn_next      = conn_reg;
        res_next       = res_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = total_reg[IDX_W-1:0];
        wr_region.link = item_reg.link_id;
        wr_region.base = sum_reg[rmts_pkg::ADDR_W-1:0];
        wr_region.bytes = item_reg.amount;

        unique case (state_reg)
            rmts_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    item_next     = q_item;
                    scan_idx_next = '0;
                    cur_next      = {1'b0, q_item.address};
                    left_next     = q_item.amount;
                end
            end
            rmts_pkg::ST_REG: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    res_next                  = rmts_pkg::RESULT_ZERO;
                    res_next.last             = 1'b1;
                    res_next.regions_in_table = 4'(total_reg);
                    if (full || sum_reg[rmts_pkg::ADDR_W]) begin
                        res_next.status = rmts_pkg::STATUS_FULL;
                    end else begin
                        wr_en                     = 1'b1;
                        conn_next[total_reg[IDX_W-1:0]] = 1'b1;
                        total_next                = total_reg + CNT_W'(1);
                        sum_next                  = sum_reg + {1'b0, item_reg.amount};
                        res_next.status           = rmts_pkg::STATUS_OK;
                        res_next.region_index     = 3'(total_reg);
                        res_next.chunk_link       = item_reg.link_id;
                        res_next.assigned_base    = sum_reg[rmts_pkg::ADDR_W-1:0];
                        res_next.regions_in_table = 4'(total_reg + CNT_W'(1));
                    end
                end
            end
            rmts_pkg::ST_ONE: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    res_next                  = rmts_pkg::RESULT_ZERO;
                    res_next.status           = rmts_pkg::STATUS_OK;
                    res_next.chunk_is_write   = item_reg.is_write;
                    res_next.regions_in_table = 4'(total_reg);
                    res_next.last             = 1'b1;
                end
            end
            rmts_pkg::ST_FAIL: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    res_next                  = rmts_pkg::RESULT_ZERO;
                    res_next.regions_in_table = 4'(total_reg);
                    res_next.last             = 1'b1;
                    if (item_reg.kind == rmts_pkg::KIND_DISCONNECT) begin
                        res_next.status = rmts_pkg::STATUS_NO_LINK;
                    end else begin
                        res_next.status         = rmts_pkg::STATUS_NO_REGION;
                        res_next.chunk_is_write = item_reg.is_write;
                    end
                end
            end
            rmts_pkg::ST_CMP: begin
                if (item_reg.kind == rmts_pkg::KIND_DISCONNECT && link_eq) begin
                    hit_idx_next  = scan_idx_reg;
                    hit_link_next = rd_region.link;
                end else if (item_reg.kind == rmts_pkg::KIND_TRANSFER && hit) begin
                    hit_idx_next  = scan_idx_reg;
                    hit_link_next = rd_region.link;
                    local_next    = cur_reg[rmts_pkg::ADDR_W-1:0] - rd_region.base;
                    avail_next    = rmts_pkg::AMOUNT_W'(end_sum - cur_reg);
                end else if (!scan_end) begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            rmts_pkg::ST_UNLINK: begin
                if (out_free) begin
                    conn_next[hit_idx_reg]    = 1'b0;
                    out_valid_next            = 1'b1;
                    res_next                  = rmts_pkg::RESULT_ZERO;
                    res_next.status           = rmts_pkg::STATUS_OK;
                    res_next.region_index     = 3'(hit_idx_reg);
                    res_next.chunk_link       = hit_link_reg;
                    res_next.regions_in_table = 4'(total_reg);
                    res_next.last             = 1'b1;
                end
            end
            rmts_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    res_next                  = rmts_pkg::RESULT_ZERO;
                    res_next.status           = rmts_pkg::STATUS_OK;
                    res_next.region_index     = 3'(hit_idx_reg);
                    res_next.chunk_link       = hit_link_reg;
                    res_next.local_address    = local_reg;
                    res_next.chunk_length     = take_all ? left_reg : avail_reg;
                    res_next.chunk_is_write   = item_reg.is_write;
                    res_next.regions_in_table = 4'(total_reg);
                    res_next.last             = take_all;
                    if (!take_all) begin
                        left_next     = left_reg - avail_reg;
                        cur_next      = cur_reg + {1'b0, avail_reg};
                        scan_idx_next = '0;
                    end
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rmts_pkg::ST_IDLE;
            scan_idx_reg  <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            conn_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            total_reg     <= total_next;
            sum_reg       <= sum_next;
            conn_reg      <= conn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        hit_idx_reg  <= hit_idx_next;
        hit_link_reg <= hit_link_next;
        local_reg    <= local_next;
        avail_reg    <= avail_next;
        left_reg     <= left_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = res_reg;

    ap_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(MAX_REGIONS))
        else $error("region count above table size");

    ap_chunk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rmts_pkg::ST_EMIT |-> avail_reg != '0)
        else $error("matched region leaves no bytes");

    ap_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rmts_pkg::ST_CMP |-> CNT_W'(scan_idx_reg) < total_reg)
        else $error("scan pointer beyond registered regions");

    ap_sum_needs_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg[rmts_pkg::ADDR_W] |-> total_reg != '0)
        else $error("base overflow with empty table");

endmodule

`default_nettype wire

// ===== design/region_map_transfer_splitter_core.sv =====
// Top level of the region map transfer splitter: port packing and the two halves.
// Register, empty transfer and empty-table error words are issued from their own state after
// acceptance; disconnect and chunk words follow a row-by-row scan of the table (ST_CMP).
// Each later chunk of a transfer rescans the table from row 0 after the previous one.
// That scan, with any output stall, sets throughput; a two-word queue keeps the input open
// while the back end is busy with an item.
// Reset (aresetn low, synchronous) empties count, connected marks and queue; rows not cleared.
`default_nettype none

module region_map_transfer_splitter_core #(
    parameter int MAX_REGIONS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input words
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // link_id[15:0], amount[47:16], address[79:48], is_write[80], zero pad
    input  wire logic [rmts_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[1:0]
    input  wire logic [rmts_pkg::OP_W-1:0]          s_tuser,
    // result words
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[1:0], region_index[4:2], chunk_link[20:5], local_address[52:21],
    // chunk_length[84:53], chunk_is_write[85], assigned_base[117:86],
    // regions_in_table[121:118], zero pad
    output logic [rmts_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast
);

    logic              q_valid;
    logic              q_pop;
    rmts_pkg::item_t   q_item;
    rmts_pkg::result_t result;

    // Front: accept and classify
    rmts_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_operation(s_tuser),
        .s_link_id  (s_tdata[15:0]),
        .s_amount   (s_tdata[47:16]),
        .s_address  (s_tdata[79:48]),
        .s_is_write (s_tdata[80]),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back: table upkeep and chunk splitting
    rmts_back #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_result(result)
    );

    // Pack the result word
    assign m_tdata = {
        {rmts_pkg::M_PAD_W{1'b0}},
        result.regions_in_table,
        result.assigned_base,
        result.chunk_is_write,
        result.chunk_length,
        result.local_address,
        result.chunk_link,
        result.region_index,
        result.status
    };
    assign m_tlast = result.last;

endmodule

`default_nettype wire
